FILE: hdl/jsc_pkg.sv
// ----------------------------------------------------------------------------
// jsc_pkg
// shared widths, byte codes, status codes, length reset defaults and register
// indexes for the jpeg stream carver
// ----------------------------------------------------------------------------
package jsc_pkg;

   localparam int BYTE_BITS         = 8;
   localparam int STATUS_BITS       = 3;
   localparam int START_FIELD_BITS  = 48;
   localparam int LENGTH_FIELD_BITS = 32;
   localparam int RSP_DATA_BITS     = START_FIELD_BITS + LENGTH_FIELD_BITS;
   localparam int CSR_ADDR_BITS     = 2;
   localparam int CSR_DATA_BITS     = 48;

   localparam logic [BYTE_BITS-1:0] BYTE_FF   = 8'hFF;
   localparam logic [BYTE_BITS-1:0] BYTE_SOI  = 8'hD8;
   localparam logic [BYTE_BITS-1:0] BYTE_EOI  = 8'hD9;
   localparam logic [BYTE_BITS-1:0] BYTE_SOF0 = 8'hC0;
   localparam logic [BYTE_BITS-1:0] BYTE_ZERO = 8'h00;

   localparam logic [LENGTH_FIELD_BITS-1:0] MIN_LENGTH_RESET = 32'd1024;
   localparam logic [LENGTH_FIELD_BITS-1:0] MAX_LENGTH_RESET = 32'h0200_0000;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_FOUND   = 3'd0,
      STATUS_SMALL   = 3'd1,
      STATUS_BIG     = 3'd2,
      STATUS_MARKER  = 3'd3,
      STATUS_RESTART = 3'd4
   } status_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_START_OFFSET = 2'd0,
      CSR_MIN_LENGTH   = 2'd1,
      CSR_MAX_LENGTH   = 2'd2
   } csr_index_type;

endpackage

FILE: hdl/jpeg_stream_carver.sv
// ----------------------------------------------------------------------------
// jpeg_stream_carver
// scans a raw byte stream for embedded jpeg images and reports each
// candidate that ends, aborts or restarts
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  req_tdata[7:0] byte_value
//   rsp      out  rsp_tvalid/rsp_tready  rsp_tdata image_start, image_length;
//                                        rsp_tuser status
//   csr      in   csr_valid/csr_ready    csr_addr index, csr_wdata value
//
// one byte per cycle sustained unless a pending result stalls; a byte waits
// in the input register, and its result is registered in the output register
// reset is synchronous and active high; control registers return to their defaults
// a stalled rsp_tready with a result pending holds the input register, the skid
// stage takes one more request and then req_tready drops until the stage drains
// csr writes are always accepted
// ----------------------------------------------------------------------------
module jpeg_stream_carver #(
   parameter int POSITION_BITS = 48,
   parameter int LENGTH_BITS   = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [jsc_pkg::BYTE_BITS-1:0]          req_tdata,   // byte_value
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [jsc_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,   // image_start, image_length
   output logic [jsc_pkg::STATUS_BITS-1:0]        rsp_tuser,   // status
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [jsc_pkg::CSR_ADDR_BITS-1:0]      csr_addr,
   input  logic [jsc_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam logic [63:0] LenSat = 64'((65'd1 << LENGTH_BITS) - 65'd1);

   typedef enum logic [1:0] {
      MODE_SCAN,
      MODE_EXPECT_FF,
      MODE_CANDIDATE
   } mode_type;

   // input register and skid stage
   logic                          s1_valid_ff, s1_valid_in;
   logic [jsc_pkg::BYTE_BITS-1:0] s1_byte_ff, s1_byte_in;
   logic                          skid_valid_ff, skid_valid_in;
   logic [jsc_pkg::BYTE_BITS-1:0] skid_byte_ff, skid_byte_in;

   // scan state
   mode_type                      mode_ff, mode_in;
   logic                          prev_ff_ff, prev_ff_in;
   logic                          pend_ff, pend_in;
   logic [POSITION_BITS-1:0]      pos_ff, pos_in;
   logic [POSITION_BITS-1:0]      cand_start_ff, cand_start_in;
   logic [POSITION_BITS-1:0]      span_ff, span_in;
   logic [jsc_pkg::LENGTH_FIELD_BITS-1:0] min_len_ff, min_len_in;
   logic [jsc_pkg::LENGTH_FIELD_BITS-1:0] max_len_ff, max_len_in;

   // result register
   logic                                     rsp_valid_ff, rsp_valid_in;
   jsc_pkg::status_type                      rsp_status_ff, rsp_status_in;
   logic [jsc_pkg::START_FIELD_BITS-1:0]     rsp_start_ff, rsp_start_in;
   logic [jsc_pkg::LENGTH_FIELD_BITS-1:0]    rsp_length_ff, rsp_length_in;

   logic                 req_fire;
   logic                 csr_fire;
   logic                 out_free;
   logic                 advance;
   logic                 s1_take;
   logic [63:0]          len_full;
   logic [63:0]          len_sat;
   logic                 result_valid;
   jsc_pkg::status_type  result_status;
   logic [jsc_pkg::BYTE_BITS-1:0] b;

   assign req_tready = !skid_valid_ff;
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_fire   = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign s1_take    = !s1_valid_ff || advance;
   assign b          = s1_byte_ff;

   // length of the open candidate through the byte in the input register
   assign len_full = 64'(span_ff) + 64'd1;
   assign len_sat  = (len_full > LenSat) ? LenSat : len_full;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_length_ff, rsp_start_ff};
   assign rsp_tuser  = rsp_status_ff;

   // input register and skid
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_byte_in    = s1_byte_ff;
      skid_valid_in = skid_valid_ff;
      skid_byte_in  = skid_byte_ff;
      if (s1_take) begin
         s1_valid_in   = skid_valid_ff || req_fire;
         s1_byte_in    = skid_valid_ff ? skid_byte_ff : req_tdata;
         skid_valid_in = 1'b0;
      end else if (req_fire) begin
         skid_valid_in = 1'b1;
         skid_byte_in  = req_tdata;
      end
   end

   // scan step
   always_comb begin
      mode_in       = mode_ff;
      prev_ff_in    = prev_ff_ff;
      pend_in       = pend_ff;
      pos_in        = pos_ff;
      cand_start_in = cand_start_ff;
      span_in       = span_ff;
      min_len_in    = min_len_ff;
      max_len_in    = max_len_ff;
      result_valid  = 1'b0;
      result_status = jsc_pkg::STATUS_FOUND;

      if (advance) begin
         pos_in  = pos_ff + POSITION_BITS'(1);
         span_in = span_ff + POSITION_BITS'(1);
         unique case (mode_ff)
            MODE_SCAN: begin
               if (prev_ff_ff && b == jsc_pkg::BYTE_SOI) begin
                  cand_start_in = pos_ff - POSITION_BITS'(1);
                  span_in       = POSITION_BITS'(2);
                  mode_in       = MODE_EXPECT_FF;
                  prev_ff_in    = 1'b0;
               end else begin
                  prev_ff_in = (b == jsc_pkg::BYTE_FF);
               end
            end
            MODE_EXPECT_FF: begin
               if (b == jsc_pkg::BYTE_FF) begin
                  mode_in = MODE_CANDIDATE;
                  pend_in = 1'b1;
               end else begin
                  mode_in    = MODE_SCAN;
                  prev_ff_in = 1'b0;
               end
            end
            MODE_CANDIDATE: begin
               priority if (len_full >= 64'(max_len_ff)) begin
                  result_valid  = 1'b1;
                  result_status = jsc_pkg::STATUS_BIG;
               end else if (pend_ff && b == jsc_pkg::BYTE_EOI) begin
                  result_valid  = 1'b1;
                  result_status = (len_full > 64'(min_len_ff)) ?
                                  jsc_pkg::STATUS_FOUND : jsc_pkg::STATUS_SMALL;
               end else if (pend_ff && b == jsc_pkg::BYTE_SOI) begin
                  result_valid  = 1'b1;
                  result_status = jsc_pkg::STATUS_RESTART;
                  cand_start_in = pos_ff - POSITION_BITS'(1);
                  span_in       = POSITION_BITS'(2);
                  mode_in       = MODE_EXPECT_FF;
                  pend_in       = 1'b0;
               end else if (pend_ff && b != jsc_pkg::BYTE_ZERO
                            && b < jsc_pkg::BYTE_SOF0) begin
                  result_valid  = 1'b1;
                  result_status = jsc_pkg::STATUS_MARKER;
               end else begin
                  pend_in = (b == jsc_pkg::BYTE_FF);
               end
               if (result_valid && result_status != jsc_pkg::STATUS_RESTART) begin
                  mode_in    = MODE_SCAN;
                  prev_ff_in = 1'b0;
                  pend_in    = 1'b0;
               end
            end
            default: begin
               mode_in = MODE_SCAN;
            end
         endcase
      end

      if (csr_fire) begin
         unique case (csr_addr)
            jsc_pkg::CSR_START_OFFSET: begin
               pos_in  = POSITION_BITS'(csr_wdata);
               span_in = POSITION_BITS'(csr_wdata) - cand_start_ff;
            end
            jsc_pkg::CSR_MIN_LENGTH: begin
               min_len_in = csr_wdata[jsc_pkg::LENGTH_FIELD_BITS-1:0];
            end
            jsc_pkg::CSR_MAX_LENGTH: begin
               max_len_in = csr_wdata[jsc_pkg::LENGTH_FIELD_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_length_in = rsp_length_ff;
      if (advance && result_valid) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = result_status;
         rsp_start_in  = jsc_pkg::START_FIELD_BITS'(cand_start_ff);
         rsp_length_in = len_sat[jsc_pkg::LENGTH_FIELD_BITS-1:0];
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff    <= s1_byte_in;
      skid_byte_ff  <= skid_byte_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_length_ff <= rsp_length_in;
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         skid_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= MODE_SCAN;
         prev_ff_ff    <= 1'b0;
         pend_ff       <= 1'b0;
         pos_ff        <= '0;
         cand_start_ff <= '0;
         span_ff       <= '0;
         min_len_ff    <= jsc_pkg::MIN_LENGTH_RESET;
         max_len_ff    <= jsc_pkg::MAX_LENGTH_RESET;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         skid_valid_ff <= skid_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         mode_ff       <= mode_in;
         prev_ff_ff    <= prev_ff_in;
         pend_ff       <= pend_in;
         pos_ff        <= pos_in;
         cand_start_ff <= cand_start_in;
         span_ff       <= span_in;
         min_len_ff    <= min_len_in;
         max_len_ff    <= max_len_in;
      end
   end

`ifndef SYNTHESIS
   a_skid_behind_s1: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> s1_valid_ff)
      else $error("skid holds a request while the input register is empty");

   a_result_from_candidate: assert property (@(posedge clock) disable iff (reset)
      (advance && result_valid) |-> (mode_ff == MODE_CANDIDATE))
      else $error("result raised outside a candidate");

   a_end_returns_to_scan: assert property (@(posedge clock) disable iff (reset)
      (advance && result_valid && result_status != jsc_pkg::STATUS_RESTART)
      |=> (mode_ff == MODE_SCAN && !prev_ff_ff && !pend_ff))
      else $error("scan did not resume after candidate end");

   a_restart_expects_ff: assert property (@(posedge clock) disable iff (reset)
      (advance && result_valid && result_status == jsc_pkg::STATUS_RESTART)
      |=> (mode_ff == MODE_EXPECT_FF && span_ff == POSITION_BITS'(2)))
      else $error("restart did not reopen the candidate");
`endif

endmodule
